[hw/rtl/bba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the first-fit bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    // field widths fixed by the command and result formats
    localparam int NUM_W    = 13;
    localparam int STATUS_W = 2;

    // default sizing of the bitmap
    localparam int MAX_BLOCKS_DEF = 4096;
    localparam int WORD_BITS_DEF  = 32;

    // block count after reset
    localparam logic [NUM_W-1:0] BLOCK_COUNT_RESET = 13'd4096;

    typedef enum logic
    {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } bba_cmd_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_ALLOC = 2'd0,
        ST_FULL  = 2'd1,
        ST_FREED = 2'd2
    } bba_status_t;

    typedef struct packed
    {
        bba_cmd_t               cmd;
        logic [NUM_W-1:0]       block_number;
    } bba_req_t;

    typedef struct packed
    {
        bba_status_t            status;
        logic [NUM_W-1:0]       allocated_block;
    } bba_rsp_t;

    typedef enum logic [1:0]
    {
        S_CLEAR,
        S_IDLE,
        S_SCAN
    } bba_state_t;

endpackage

[hw/rtl/bba_bitmap_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_bitmap_ram
// Bitmap word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bba_bitmap_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and synchronous read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/bba_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer of the allocator: clearing pass, word-by-word scan with
// read-modify-write of the bitmap, and the registered result beat.
// ----------------------------------------------------------------------------
module bba_ctrl #(
    parameter int MAX_BLOCKS = 4096,
    parameter int WORD_BITS  = 32,
    parameter int WORD_COUNT = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS,
    parameter int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1,
    parameter int LIVE_W     = 13
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  bba_pkg::bba_req_t     req,
    input  logic [LIVE_W-1:0]     live,
    output logic                  busy,
    output logic                  done,
    output bba_pkg::bba_rsp_t     rsp,
    output logic                  wr_en,
    output logic [ADDR_W-1:0]     wr_addr,
    output logic [WORD_BITS-1:0]  wr_data,
    output logic                  rd_en,
    output logic [ADDR_W-1:0]     rd_addr,
    input  logic [WORD_BITS-1:0]  rd_data
);

    import bba_pkg::*;

    localparam int BIT_W = $clog2(WORD_BITS);
    localparam int IDX_W = LIVE_W + 1;

    bba_state_t          state_reg, state_next;
    logic [ADDR_W-1:0]   word_reg, word_next;
    logic [IDX_W-1:0]    base_reg, base_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    bba_cmd_t            op_reg, op_next;
    bba_rsp_t            rsp_reg, rsp_next;
    logic                done_reg, done_next;

    logic [IDX_W-1:0]     rem;
    logic                 last_word;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] free_bits;
    logic                 found;
    logic [BIT_W-1:0]     pos;
    logic [IDX_W-1:0]     off;
    logic                 in_word;
    logic                 free_ok;
    logic                 go_scan;
    logic                 scan_end;
    logic                 clear_last;

    // blocks of the current word that lie below the live count
    assign rem       = IDX_W'(live) - base_reg;
    assign last_word = (rem <= IDX_W'(WORD_BITS));

    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            mask[b] = (IDX_W'(b) < rem);
        end
    end

    // lowest free block of the word
    assign free_bits = ~rd_data & mask;
    assign found     = |free_bits;

    always_comb
    begin
        pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (free_bits[b])
            begin
                pos = BIT_W'(b);
            end
        end
    end

    // position of the block to release relative to the current word
    assign off     = idx_reg - base_reg;
    assign in_word = (off < IDX_W'(WORD_BITS));

    // request decode
    assign free_ok    = (req.block_number != '0) &&
                        (IDX_W'(req.block_number) <= IDX_W'(live));
    assign go_scan    = (req.cmd == CMD_ALLOC) ? (live != '0) : free_ok;
    assign scan_end   = (op_reg == CMD_ALLOC) ? (found || last_word) : in_word;
    assign clear_last = (word_reg == ADDR_W'(WORD_COUNT - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start && go_scan)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memory control, datapath and result
    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr   = word_reg + ADDR_W'(1);
        wr_en     = 1'b0;
        wr_addr   = word_reg;
        wr_data   = '0;
        done_next = 1'b0;
        rsp_next  = rsp_reg;
        word_next = word_reg;
        base_next = base_reg;
        idx_next  = idx_reg;
        op_next   = op_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en     = 1'b1;
                word_next = clear_last ? '0 : word_reg + ADDR_W'(1);
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next   = req.cmd;
                    idx_next  = IDX_W'(req.block_number) - IDX_W'(1);
                    word_next = '0;
                    base_next = '0;
                    if (go_scan)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                    end
                    else
                    begin
                        done_next                = 1'b1;
                        rsp_next.status          = (req.cmd == CMD_ALLOC) ? ST_FULL
                                                                         : ST_FREED;
                        rsp_next.allocated_block = '0;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    done_next                = 1'b1;
                    rsp_next.allocated_block = '0;
                    if (op_reg == CMD_ALLOC)
                    begin
                        if (found)
                        begin
                            wr_en                    = 1'b1;
                            wr_data                  = rd_data |
                                                       (WORD_BITS'(1) << pos);
                            rsp_next.status          = ST_ALLOC;
                            rsp_next.allocated_block =
                                NUM_W'(base_reg + IDX_W'(pos) + IDX_W'(1));
                        end
                        else
                        begin
                            rsp_next.status = ST_FULL;
                        end
                    end
                    else
                    begin
                        wr_en           = 1'b1;
                        wr_data         = rd_data &
                                          ~(WORD_BITS'(1) << off[BIT_W-1:0]);
                        rsp_next.status = ST_FREED;
                    end
                end
                else
                begin
                    // fetch the next word while this one is judged
                    rd_en     = 1'b1;
                    word_next = word_reg + ADDR_W'(1);
                    base_next = base_reg + IDX_W'(WORD_BITS);
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            word_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            word_reg  <= word_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        idx_reg  <= idx_next;
        op_reg   <= op_next;
        rsp_reg  <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

[hw/rtl/bitmap_block_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit allocator over a used/free bitmap held in a synchronous RAM.
// ----------------------------------------------------------------------------
// Scan: an allocate reads words from 0 up to the word that holds its block, or
// up to the last live word for a full result; a free of block n reads words up
// to the one that holds n; invalid frees and zero-count allocates answer from idle.
// Throughput: one bitmap word per cycle, one request at a time, next start
// accepted in the cycle the result beat is shown; results are never stalled.
// Reset: a clearing pass over all WORD_COUNT words (128 by default), busy high.
module bitmap_block_allocator #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
    parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  bba_pkg::bba_req_t       req,
    output logic                    done,
    output bba_pkg::bba_rsp_t       rsp,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [bba_pkg::NUM_W-1:0] cfg_data
);

    import bba_pkg::*;

    localparam int WORD_COUNT = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int LIVE_W     = ($clog2(MAX_BLOCKS + 1) > NUM_W) ?
                                $clog2(MAX_BLOCKS + 1) : NUM_W;

    logic [NUM_W-1:0]     count_reg;
    logic [LIVE_W-1:0]    live;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [WORD_BITS-1:0] rd_data;

    // block count register, written by a configuration beat
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= BLOCK_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            count_reg <= cfg_data;
        end
    end

    // live count limited to the bitmap size
    assign live = (LIVE_W'(count_reg) > LIVE_W'(MAX_BLOCKS)) ? LIVE_W'(MAX_BLOCKS)
                                                             : LIVE_W'(count_reg);

    bba_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .WORD_BITS  (WORD_BITS),
        .WORD_COUNT (WORD_COUNT),
        .ADDR_W     (ADDR_W),
        .LIVE_W     (LIVE_W)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .req     (req),
        .live    (live),
        .busy    (busy),
        .done    (done),
        .rsp     (rsp),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bba_bitmap_ram #(
        .DEPTH  (WORD_COUNT),
        .WIDTH  (WORD_BITS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

[verif/tb_bitmap_block_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_block_allocator
// Self-checking bench for the first-fit bitmap block allocator. Requests go
// in one at a time through the start/busy port in bursts with random gaps.
// A bit-level model of the bitmap and the block count predicts each result
// beat, and a checker compares every beat field by field in order. Directed
// tests cover first-fit order, ignored frees, zero, one and oversized block
// counts and a lowered count. Random phases then reconfigure the count and
// mix allocates, frees of used blocks and arbitrary frees.
// ----------------------------------------------------------------------------
module tb_bitmap_block_allocator;
    import bba_pkg::*;

    localparam int BLOCKS         = MAX_BLOCKS_DEF;
    localparam int WORD_COUNT     = BLOCKS / WORD_BITS_DEF;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    bba_req_t            req;
    logic                done;
    bba_rsp_t            rsp;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [NUM_W-1:0]    cfg_data;

    // model state: one used flag per block and the block count register
    logic                block_used [BLOCKS];
    logic [NUM_W-1:0]    count_reg;

    bba_rsp_t            expected_rsp [$];
    bba_rsp_t            expected_now;
    int unsigned         mismatches;
    int unsigned         stall_cycles;

    bitmap_block_allocator #(
        .MAX_BLOCKS (BLOCKS),
        .WORD_BITS  (WORD_BITS_DEF)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // blocks actually managed: the count clamped to the bitmap size
    function automatic int unsigned live_blocks(logic [NUM_W-1:0] count);
        return (count > BLOCKS) ? BLOCKS : count;
    endfunction

    // first-fit allocate or free on the model bitmap, giving the result
    function automatic bba_rsp_t model_request(bba_req_t r);
        bba_rsp_t    result;
        int unsigned live;
        bit          found;
        live = live_blocks(count_reg);
        result.status = ST_FREED;
        result.allocated_block = '0;
        found = 1'b0;
        if (r.cmd == CMD_ALLOC)
        begin
            result.status = ST_FULL;
            for (int i = 0; i < live && !found; i++)
            begin
                if (!block_used[i])
                begin
                    block_used[i] = 1'b1;
                    found = 1'b1;
                    result.status = ST_ALLOC;
                    result.allocated_block = NUM_W'(i + 1);
                end
            end
        end
        else if (r.block_number >= 1 && r.block_number <= live)
        begin
            block_used[r.block_number - 1] = 1'b0;
        end
        return result;
    endfunction

    // one request beat, held until accepted, then predicted
    task automatic issue_request(bba_cmd_t c, logic [NUM_W-1:0] num);
        bba_req_t r;
        r.cmd = c;
        r.block_number = num;
        @(negedge clk);
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        expected_rsp.push_back(model_request(r));
    endtask

    // sender gap
    task automatic pause_sender(int unsigned cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_pending();
        @(negedge clk);
        start <= 1'b0;
        while (expected_rsp.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // block count write, only with the allocator idle
    task automatic write_block_count(logic [NUM_W-1:0] value);
        drain_pending();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        count_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // lowest free blocks come out in order after reset
    task automatic test_first_fit_order();
        issue_request(CMD_ALLOC, '0);
        issue_request(CMD_ALLOC, 13'h1FFF);
        issue_request(CMD_ALLOC, 13'd77);
        issue_request(CMD_FREE, 13'd2);
        issue_request(CMD_ALLOC, '0);
        issue_request(CMD_FREE, 13'd4096);
    endtask

    // block zero, beyond the count and already free
    task automatic test_invalid_frees();
        issue_request(CMD_FREE, 13'd0);
        issue_request(CMD_FREE, 13'h1FFF);
        issue_request(CMD_FREE, 13'd2);
        issue_request(CMD_FREE, 13'd2);
        issue_request(CMD_FREE, 13'd4097);
    endtask

    // one managed block: full, freed, taken again
    task automatic test_single_block();
        write_block_count(13'd1);
        issue_request(CMD_ALLOC, '0);
        issue_request(CMD_FREE, 13'd1);
        issue_request(CMD_ALLOC, '0);
        issue_request(CMD_ALLOC, '0);
        issue_request(CMD_FREE, 13'd2);
    endtask

    // no block managed: always full, frees ignored
    task automatic test_zero_count();
        write_block_count(13'd0);
        issue_request(CMD_ALLOC, '0);
        issue_request(CMD_FREE, 13'd1);
    endtask

    // count above the bitmap size is clamped
    task automatic test_count_above_max();
        write_block_count(13'h1FFF);
        issue_request(CMD_ALLOC, '0);
        issue_request(CMD_FREE, 13'd4097);
        issue_request(CMD_FREE, 13'h1FFF);
        issue_request(CMD_ALLOC, '0);
    endtask

    // used blocks above a lowered count are kept but out of reach
    task automatic test_lowered_count();
        write_block_count(13'd2);
        issue_request(CMD_ALLOC, '0);
        issue_request(CMD_FREE, 13'd3);
        write_block_count(13'd16);
        issue_request(CMD_FREE, 13'd3);
        issue_request(CMD_ALLOC, '0);
    endtask

    // random phases, each under a new block count
    task automatic test_random_traffic();
        int unsigned      sent;
        int unsigned      phase_len;
        int unsigned      burst_left;
        int unsigned      live;
        int unsigned      span;
        int unsigned      pick;
        logic [NUM_W-1:0] count_val;
        logic [NUM_W-1:0] num;
        sent = 0;
        burst_left = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       count_val = '0;
                1:       count_val = NUM_W'(BLOCKS);
                2:       count_val = NUM_W'($urandom_range(BLOCKS + 1, 8191));
                3:       count_val = NUM_W'($urandom_range(0, 8191));
                default: count_val = NUM_W'($urandom_range(1, 96));
            endcase
            write_block_count(count_val);
            live = live_blocks(count_val);
            span = (live < 160) ? live : 160;
            phase_len = $urandom_range(40, 110);
            repeat (phase_len)
            begin
                // bursts of random length, sometimes long ones
                if (burst_left == 0)
                begin
                    pause_sender($urandom_range(1, 12));
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                             : $urandom_range(1, 12);
                end
                burst_left--;
                pick = $urandom_range(0, 99);
                if (pick < 50)
                begin
                    issue_request(CMD_ALLOC, NUM_W'($urandom));
                end
                else if (pick < 85 && span != 0)
                begin
                    // aim at a block that is in use
                    num = NUM_W'($urandom_range(1, span));
                    for (int t = 0; t < 3 && !block_used[num - 1]; t++)
                        num = NUM_W'($urandom_range(1, span));
                    issue_request(CMD_FREE, num);
                end
                else
                begin
                    issue_request(CMD_FREE, NUM_W'($urandom));
                end
                sent++;
            end
        end
    endtask

    // result checker: every beat against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ($isunknown(done))
            begin
                $error("done: expected 0 or 1, actual %b", done);
                mismatches++;
            end
            else if (done)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $error("result beat with nothing expected: status %0d block %0d",
                           rsp.status, rsp.allocated_block);
                    mismatches++;
                end
                else
                begin
                    expected_now = expected_rsp.pop_front();
                    if (rsp.status !== expected_now.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               expected_now.status, rsp.status);
                        mismatches++;
                    end
                    if (rsp.allocated_block !== expected_now.allocated_block)
                    begin
                        $error("allocated_block: expected %0d, actual %0d",
                               expected_now.allocated_block, rsp.allocated_block);
                        mismatches++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no beat of any kind
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // reset, test sequence and final verdict
    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        req        = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        mismatches = 0;
        count_reg  = BLOCK_COUNT_RESET;
        for (int i = 0; i < BLOCKS; i++)
            block_used[i] = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_first_fit_order();
        test_invalid_frees();
        test_single_block();
        test_zero_count();
        test_count_above_max();
        test_lowered_count();
        test_random_traffic();

        drain_pending();
        repeat (WORD_COUNT + 8) @(negedge clk);
        if (expected_rsp.size() != 0)
        begin
            $error("results still expected at the end: %0d", expected_rsp.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/bba_pkg.sv
hw/rtl/bba_bitmap_ram.sv
hw/rtl/bba_ctrl.sv
hw/rtl/bitmap_block_allocator.sv
verif/tb_bitmap_block_allocator.sv
